/* design/slc_pkg.sv */
// shared types and constants for the scalar literal classifier
// no dependencies; used by slc_step and scalar_literal_classifier
package slc_pkg;

  localparam int PSEUDO_COUNT = 13;
  localparam int PSEUDO_FLOAT_COUNT = 7;
  localparam int TEXT_SLOTS = 8;

  localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;

  localparam int NF_DOT = 0;
  localparam int NF_EXP = 1;
  localparam int NF_BEFORE = 2;
  localparam int NF_AFTER = 3;
  localparam int NF_SUFFIX = 4;
  localparam int NF_BAD = 5;

  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_INT     = 3'd2,
    KIND_FLOAT   = 3'd3,
    KIND_FPSEUDO = 3'd4,
    KIND_DPSEUDO = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]              count;
    logic [7:0]              prev;
    logic [30:0]             acc;
    logic                    ovf;
    logic                    all_dig;
    logic [5:0]              flags;
    logic [PSEUDO_COUNT-1:0] match;
  } lit_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] int_value;
    logic [7:0]  char_value;
    logic        displayable;
    logic        impossible;
  } lit_result_t;

  localparam lit_state_t STATE_CLEAR = '{
    count:   3'd0,
    prev:    8'h00,
    acc:     31'd0,
    ovf:     1'b0,
    all_dig: 1'b1,
    flags:   6'd0,
    match:   {PSEUDO_COUNT{1'b1}}
  };

  // -inff +inff inff nanf NaNf NANf NANF -inf +inf inf nan NaN NAN
  localparam logic [7:0] PSEUDO_TEXT [PSEUDO_COUNT][TEXT_SLOTS] = '{
    '{8'h2D, 8'h69, 8'h6E, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h69, 8'h6E, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6E, 8'h61, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4E, 8'h61, 8'h4E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4E, 8'h41, 8'h4E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4E, 8'h41, 8'h4E, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2D, 8'h69, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h69, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6E, 8'h61, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4E, 8'h61, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4E, 8'h41, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] PSEUDO_LEN [PSEUDO_COUNT] = '{
    4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3
  };

endpackage

/* design/slc_step.sv */
// per-character update of the literal state and classification of the literal
// depends on slc_pkg
module slc_step (
  input  logic [7:0]          ch,
  input  logic                last,
  input  slc_pkg::lit_state_t st,
  output slc_pkg::lit_state_t st_nxt,
  output slc_pkg::lit_result_t res
);
  import slc_pkg::*;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_F_UP  = 8'h46;

  lit_state_t  upd;
  logic        dig;
  logic [2:0]  pos;
  logic [3:0]  pos1;
  logic [34:0] sum;
  logic [5:0]  f;
  logic        found;

  always_comb begin
    pos   = st.count;
    pos1  = {1'b0, pos} + 4'd1;
    dig   = ch inside {[8'h30:8'h39]};
    upd   = st;
    found = 1'b0;
    res   = '{kind: KIND_INVALID, int_value: 31'd0, char_value: 8'h00,
              displayable: 1'b0, impossible: 1'b0};

    // decimal accumulation
    sum = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {31'd0, ch[3:0]};
    if (!dig) begin
      upd.all_dig = 1'b0;
    end else if (st.all_dig && !st.ovf) begin
      if (sum > {4'd0, INT_LIMIT}) begin
        upd.ovf = 1'b1;
      end else begin
        upd.acc = sum[30:0];
      end
    end

    // float form tracking
    f = st.flags;
    if (f[NF_SUFFIX]) begin
      f[NF_BAD] = 1'b1;
    end else if (dig) begin
      if (f[NF_EXP]) f[NF_AFTER] = 1'b1;
      else f[NF_BEFORE] = 1'b1;
    end else if (ch == CH_DOT) begin
      if (f[NF_DOT] || f[NF_EXP]) f[NF_BAD] = 1'b1;
      else f[NF_DOT] = 1'b1;
    end else if (ch == CH_E_LO || ch == CH_E_UP) begin
      if (f[NF_EXP] || !f[NF_BEFORE]) f[NF_BAD] = 1'b1;
      else f[NF_EXP] = 1'b1;
    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
      if (pos != 3'd0 && st.prev != CH_E_LO && st.prev != CH_E_UP) f[NF_BAD] = 1'b1;
    end else if (ch == CH_F_LO || ch == CH_F_UP) begin
      if (!(f[NF_BEFORE] || f[NF_AFTER])) f[NF_BAD] = 1'b1;
      else f[NF_SUFFIX] = 1'b1;
    end else begin
      f[NF_BAD] = 1'b1;
    end
    upd.flags = f;

    // pseudo-literal candidates
    for (int k = 0; k < PSEUDO_COUNT; k++) begin
      if ({1'b0, pos} >= PSEUDO_LEN[k] || PSEUDO_TEXT[k][pos] != ch) begin
        upd.match[k] = 1'b0;
      end
    end

    upd.prev  = ch;
    upd.count = (pos == 3'd7) ? 3'd7 : pos1[2:0];

    // classification
    if (pos == 3'd0 && !dig) begin
      res.kind = KIND_CHAR;
      if (ch inside {[8'h20:8'h7E]}) begin
        res.int_value   = {23'd0, ch};
        res.char_value  = ch;
        res.displayable = 1'b1;
      end else begin
        res.impossible = 1'b1;
      end
    end else if (upd.all_dig) begin
      res.kind = KIND_INT;
      if (upd.ovf) begin
        res.impossible = 1'b1;
      end else begin
        res.int_value   = upd.acc;
        res.char_value  = upd.acc[7:0];
        res.displayable = upd.acc[7:0] inside {[8'h20:8'h7E]};
      end
    end else if (!f[NF_BAD] && (f[NF_EXP] ? (f[NF_BEFORE] && f[NF_AFTER]) : f[NF_BEFORE])) begin
      res.kind = KIND_FLOAT;
    end else begin
      for (int k = 0; k < PSEUDO_COUNT; k++) begin
        if (!found && upd.match[k] && PSEUDO_LEN[k] == pos1) begin
          found          = 1'b1;
          res.kind       = (k < PSEUDO_FLOAT_COUNT) ? KIND_FPSEUDO : KIND_DPSEUDO;
          res.impossible = 1'b1;
        end
      end
    end

    st_nxt = last ? STATE_CLEAR : upd;
  end

endmodule

/* design/scalar_literal_classifier.sv */
// top level of the scalar literal classifier: input register, state, result register
// depends on slc_pkg and slc_step
//
// A literal arrives one byte per request, with in_last on its final byte; exactly one
// result follows each literal, loaded into the result register when the final byte
// leaves the input register. Unless in_stall holds the input, one byte is accepted
// every cycle: the per-literal state (digit accumulator, float form flags, pseudo-literal
// candidates) updates in combinational logic between the input register and the
// result register, and the result register lets a new byte in while a result waits.
// in_stall rises only when a final byte must wait for an occupied, stalled result.
module scalar_literal_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output slc_pkg::kind_t     out_kind,
  output logic [30:0]        out_int_value,
  output logic [7:0]         out_char_value,
  output logic               out_displayable,
  output logic               out_impossible
);
  import slc_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_ch_r;
  logic        s1_last_r;
  logic        s1_go;
  lit_state_t  st_r;
  lit_state_t  st_nxt;
  lit_result_t res_nxt;
  lit_result_t res_r;
  logic        out_valid_r;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;

  slc_step u_step (
    .ch     (s1_ch_r),
    .last   (s1_last_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_CLEAR;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_int_value   = res_r.int_value;
  assign out_char_value  = res_r.char_value;
  assign out_displayable = res_r.displayable;
  assign out_impossible  = res_r.impossible;

endmodule

/* tb/tb_scalar_literal_classifier.sv */
// self-checking testbench for scalar_literal_classifier: literals go in byte by byte and
// every result is checked against an in-bench classifier of its own
// depends on slc_pkg (kind_t, lit_result_t) and the scalar_literal_classifier rtl
`timescale 1ns / 1ps

module tb_scalar_literal_classifier;
  import slc_pkg::*;

  localparam int ITEMS = 1100;
  localparam int LIMIT = 300000;
  localparam int FLOAT_WORDS = 7;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 80;
  localparam string NEAR_CHARS = "0123456789.eE+-fFinaNAF";

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       hold;
  } lit_request_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic [7:0]     in_ch;
  logic           in_last;
  logic           out_valid;
  logic           out_stall;
  kind_t          out_kind;
  logic [30:0]    out_int_value;
  logic [7:0]     out_char_value;
  logic           out_displayable;
  logic           out_impossible;

  scalar_literal_classifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_int_value   (out_int_value),
    .out_char_value  (out_char_value),
    .out_displayable (out_displayable),
    .out_impossible  (out_impossible)
  );

  string pseudo_words [13] = '{"-inff", "+inff", "inff", "nanf", "NaNf", "NANf", "NANF",
                               "-inf", "+inf", "inf", "nan", "NaN", "NAN"};

  lit_request_t  pending [$];
  logic [7:0]    lit_buf [$];
  lit_result_t   results_due [$];

  // classifier state
  logic [2:0]    lit_len;
  logic [7:0]    lit_first;
  logic [7:0]    lit_prev;
  logic [30:0]   lit_acc;
  logic          lit_ovf;
  logic          lit_all_dig;
  logic          form_dot, form_exp, form_before, form_after, form_suffix, form_bad;
  logic [12:0]   pseudo_live;

  int            cycles;
  int            errors;
  int            bytes_queued;
  int            literals;
  int            results_checked;
  int            kinds_seen [6];
  int            gap_left;
  int            burst_left;
  int            drains;
  int            hold_left;
  int            hold_count;
  int            hold_mark = 40;
  int            stall_mode;
  int            mode_left;
  logic          in_taken;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_printable(logic [7:0] c);
    return c >= 8'h20 && c <= 8'h7E;
  endfunction

  task automatic clear_literal();
    lit_len = 3'd0;
    lit_first = 8'h00;
    lit_prev = 8'h00;
    lit_acc = 31'd0;
    lit_ovf = 1'b0;
    lit_all_dig = 1'b1;
    {form_dot, form_exp, form_before, form_after, form_suffix, form_bad} = 6'd0;
    pseudo_live = '1;
  endtask

  task automatic classify_byte(input logic [7:0] c, input logic fin);
    logic [2:0]  pos;
    logic [34:0] v;
    lit_result_t r;
    logic        found;
    pos = lit_len;
    if (pos == 3'd0) lit_first = c;
    if (!is_digit(c)) lit_all_dig = 1'b0;
    else if (lit_all_dig && !lit_ovf) begin
      v = 35'(lit_acc) * 35'd10 + 35'(c) - 35'h30;
      if (v > 35'h7FFF_FFFF) lit_ovf = 1'b1;
      else lit_acc = v[30:0];
    end
    // float form tracking
    if (form_suffix) form_bad = 1'b1;
    else if (is_digit(c)) begin
      if (form_exp) form_after = 1'b1;
      else form_before = 1'b1;
    end else if (c == ".") begin
      if (form_dot || form_exp) form_bad = 1'b1;
      else form_dot = 1'b1;
    end else if (c == "e" || c == "E") begin
      if (form_exp || !form_before) form_bad = 1'b1;
      else form_exp = 1'b1;
    end else if (c == "+" || c == "-") begin
      if (pos != 3'd0 && lit_prev != "e" && lit_prev != "E") form_bad = 1'b1;
    end else if (c == "f" || c == "F") begin
      if (!(form_before || form_after)) form_bad = 1'b1;
      else form_suffix = 1'b1;
    end else begin
      form_bad = 1'b1;
    end
    for (int k = 0; k < 13; k++) begin
      if (pos >= pseudo_words[k].len() || pseudo_words[k][pos] != c) pseudo_live[k] = 1'b0;
    end
    lit_prev = c;
    lit_len = (pos < 3'd7) ? pos + 3'd1 : 3'd7;
    if (fin) begin
      r = '0;
      r.kind = KIND_INVALID;
      if (pos == 3'd0 && !is_digit(lit_first)) begin
        r.kind = KIND_CHAR;
        if (is_printable(lit_first)) begin
          r.int_value = 31'(lit_first);
          r.char_value = lit_first;
          r.displayable = 1'b1;
        end else begin
          r.impossible = 1'b1;
        end
      end else if (lit_all_dig) begin
        r.kind = KIND_INT;
        if (lit_ovf) begin
          r.impossible = 1'b1;
        end else begin
          r.int_value = lit_acc;
          r.char_value = lit_acc[7:0];
          r.displayable = is_printable(lit_acc[7:0]);
        end
      end else if (!form_bad && (form_exp ? (form_before && form_after) : form_before)) begin
        r.kind = KIND_FLOAT;
      end else begin
        found = 1'b0;
        for (int k = 0; k < 13; k++) begin
          if (!found && pseudo_live[k] && pseudo_words[k].len() == int'(pos) + 1) begin
            if (k < FLOAT_WORDS) r.kind = KIND_FPSEUDO;
            else r.kind = KIND_DPSEUDO;
            r.impossible = 1'b1;
            found = 1'b1;
          end
        end
      end
      results_due.push_back(r);
      kinds_seen[r.kind]++;
      literals++;
      clear_literal();
    end
  endtask

  // stimulus building
  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) lit_buf.push_back(s[i]);
  endtask

  task automatic emit_literal();
    for (int i = 0; i < lit_buf.size(); i++) begin
      pending.push_back('{ch: lit_buf[i], last: (i == lit_buf.size() - 1), hold: 1'b0});
      bytes_queued++;
    end
    lit_buf.delete();
  endtask

  task automatic queue_text(string s);
    add_text(s);
    emit_literal();
  endtask

  task automatic add_drain();
    pending.push_back('{ch: 8'h00, last: 1'b0, hold: 1'b1});
  endtask

  task automatic float_form();
    int nb;
    int nf;
    logic dot;
    if ($urandom_range(0, 2) == 0) lit_buf.push_back(pick("+-"));
    nb = $urandom_range(0, 3);
    dot = $urandom_range(0, 1);
    nf = dot ? $urandom_range(0, 3) : 0;
    if (nb == 0 && nf == 0) nb = 1;
    repeat (nb) lit_buf.push_back(rand_digit());
    if (dot) lit_buf.push_back(".");
    repeat (nf) lit_buf.push_back(rand_digit());
    if ($urandom_range(0, 2) == 0) begin
      lit_buf.push_back(pick("eE"));
      if ($urandom_range(0, 1)) lit_buf.push_back(pick("+-"));
      repeat ($urandom_range(0, 3)) lit_buf.push_back(rand_digit());
    end
    if ($urandom_range(0, 2) == 0) lit_buf.push_back(pick("fF"));
  endtask

  // alters a generated literal at one random spot
  task automatic mangle();
    int p;
    p = $urandom_range(0, lit_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: lit_buf[p] = pick(NEAR_CHARS);
      1: lit_buf.insert(p, pick(NEAR_CHARS));
      2: if (lit_buf.size() > 1) lit_buf.delete(p);
      default: lit_buf[p] = 8'($urandom_range(0, 255));
    endcase
  endtask

  task automatic random_literal();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      lit_buf.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 32) begin
      case ($urandom_range(0, 3))
        0: add_text($sformatf("%0d", $urandom));
        1: add_text({"214748364", $sformatf("%0d", $urandom_range(5, 9))});
        2: add_text({"2147483647", $sformatf("%0d", $urandom_range(0, 99))});
        default: repeat ($urandom_range(1, 6)) lit_buf.push_back(rand_digit());
      endcase
    end else if (sel < 62) begin
      float_form();
      if ($urandom_range(0, 4) == 0) mangle();
    end else if (sel < 78) begin
      add_text(pseudo_words[$urandom_range(0, 12)]);
      if ($urandom_range(0, 3) == 0) mangle();
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1)) lit_buf.push_back(8'($urandom_range(0, 255)));
        else lit_buf.push_back(pick(NEAR_CHARS));
      end
    end
    emit_literal();
  endtask

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender: bursts of requests with random gaps, drains at hold markers
  always @(negedge clk) begin : sender
    lit_request_t it;
    logic         nv;
    if (rst_n && !(in_valid && !in_taken)) begin
      nv = 1'b0;
      if (pending.size() > 0 && pending[0].hold && results_due.size() == 0) begin
        void'(pending.pop_front());
        drains++;
      end
      if (pending.size() > 0 && !pending[0].hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          it = pending.pop_front();
          in_ch <= it.ch;
          in_last <= it.last;
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
          end
        end
      end
      in_valid <= nv;
    end
  end

  // receiver: stall pattern of its own plus long hold-offs
  always @(negedge clk) begin : receiver
    logic stall_next;
    stall_next = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (results_checked >= hold_mark && hold_count < 2) begin
      hold_left = HOLD_CYCLES - 1;
      hold_count++;
      hold_mark += 100;
      stall_next = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        default: stall_next = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_stall <= stall_next;
  end

  // results checked first, then the accepted request is classified
  always @(posedge clk) begin : monitor
    lit_result_t want;
    cycles++;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d", $time, out_kind);
          errors++;
        end else begin
          want = results_due.pop_front();
          field_check("kind", 32'(want.kind), 32'(out_kind));
          field_check("int_value", 32'(want.int_value), 32'(out_int_value));
          field_check("char_value", 32'(want.char_value), 32'(out_char_value));
          field_check("displayable", 32'(want.displayable), 32'(out_displayable));
          field_check("impossible", 32'(want.impossible), 32'(out_impossible));
          results_checked++;
        end
      end
      if (in_taken) classify_byte(in_ch, in_last);
    end
  end

  initial begin
    int next_drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = 8'h00;
    in_last = 1'b0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    clear_literal();

    // directed: unprintable char, printable char, single digit, int overflow,
    // float pseudo, full float form, dangling exponent
    lit_buf.push_back(8'h00);
    emit_literal();
    queue_text("~");
    queue_text("7");
    queue_text("2147483648");
    queue_text("-inff");
    queue_text("1.5e-3f");
    queue_text("1e");
    add_drain();

    next_drain = 400;
    while (bytes_queued < ITEMS) begin
      random_literal();
      if (bytes_queued >= next_drain) begin
        add_drain();
        next_drain += 400;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(pending.size() == 0 && !in_valid && results_due.size() == 0) && cycles < LIMIT)
      @(posedge clk);
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due.size());
      $display("** scalar_literal_classifier: FAILED **");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display(
        "%0d literals in %0d bytes: invalid %0d, char %0d, int %0d, float %0d, pseudo %0d/%0d",
        literals, bytes_queued, kinds_seen[0], kinds_seen[1], kinds_seen[2],
        kinds_seen[3], kinds_seen[4], kinds_seen[5]);
      $display("%0d results checked, %0d errors, %0d receiver hold-offs, %0d sender drains",
               results_checked, errors, hold_count, drains);
      if (errors == 0 && results_due.size() == 0) begin
        $display("** scalar_literal_classifier: PASSED **");
      end else begin
        $display("** scalar_literal_classifier: FAILED **");
      end
    end
    $finish;
  end

endmodule

/* sim.f */
design/slc_pkg.sv
design/slc_step.sv
design/scalar_literal_classifier.sv
tb/tb_scalar_literal_classifier.sv
